// ===== rtl/core/gcia_pkg.sv =====
// package: types, constants and codes for the grid corner index allocator
`timescale 1ns / 1ps

package gcia_pkg;

    localparam int MAX_CELLS_PER_AXIS = 31;
    localparam int CELL_W             = 5;
    localparam int COORD_W            = 5;
    localparam int ID_W               = 15;
    localparam int CNT_W              = ID_W + 1;
    localparam int ADDR_W             = 15;
    localparam int MEM_DEPTH          = 1 << ADDR_W;
    localparam int SX_W               = CELL_W + 1;
    localparam int SXY_W              = 2 * CELL_W + 1;
    localparam int SUM_W              = 16;
    localparam int CFG_IDX_W          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] corner_x;
        logic [COORD_W-1:0] corner_y;
        logic [COORD_W-1:0] corner_z;
    } gcia_in_t;

    typedef struct packed {
        logic [ID_W-1:0] corner_id;
        logic            newly_allocated;
        logic            out_of_range;
    } gcia_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CHECK,
        ST_DECIDE
    } gcia_state_t;

    function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] value);
        logic [CELL_W:0] limit;
        limit = (CELL_W + 1)'(MAX_CELLS_PER_AXIS);
        if ({1'b0, value} > limit)
            return limit[CELL_W-1:0];
        return value;
    endfunction

endpackage

// ===== rtl/core/grid_corner_index_allocator.sv =====
// top level: grid corner index allocator with cross-checked id tables
`timescale 1ns / 1ps

//  channel   signals                                   direction  transaction
//  ------    ----------------------------------------  ---------  --------------------------
//  command   start, busy, corner                       in         start && !busy
//  result    done, result                              out        done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
//  an in-range corner goes from command to the next free slot through the accept cycle,
//  a read of the corner table, a dependent read of the owner table, then the decision and
//  write back. an out-of-range corner skips both table reads, and the block stays idle.
//  reset and any cell count write zero the id counter but leave both tables; an entry
//  counts as allocated when its id is below the counter and the owner table points back to
//  it, so no clearing pass runs. the receiver cannot stall; results are never held.

module grid_corner_index_allocator
    import gcia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gcia_in_t             corner,
    output logic                 done,
    output gcia_out_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CELL_W-1:0]    cfg_data
);

    gcia_state_t        state_reg, state_next;

    logic [CELL_W-1:0]  cells_x_reg, cells_x_next;
    logic [CELL_W-1:0]  cells_y_reg, cells_y_next;
    logic [CELL_W-1:0]  cells_z_reg, cells_z_next;
    logic [SX_W-1:0]    sx_reg, sx_next;
    logic [SXY_W-1:0]   sxy_reg, sxy_next;
    logic [CNT_W-1:0]   next_id_reg, next_id_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               done_reg, done_next;
    gcia_out_t          result_reg, result_next;

    logic [ID_W-1:0]    fwd_mem [MEM_DEPTH];
    logic [ADDR_W-1:0]  rev_mem [MEM_DEPTH];
    logic [ID_W-1:0]    fwd_q;
    logic [ADDR_W-1:0]  rev_q;

    logic               accept;
    logic               cfg_write;
    logic               in_range;
    logic               lookup_hit;
    logic               alloc;
    logic [SUM_W-1:0]   prod_z;
    logic [SUM_W-1:0]   prod_y;
    logic [SUM_W-1:0]   addr_sum;
    logic [SX_W-1:0]    sy_next;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;
    assign done      = done_reg;
    assign result    = result_reg;

    // linear corner address
    assign in_range = (corner.corner_x <= cells_x_reg) && (corner.corner_y <= cells_y_reg)
                      && (corner.corner_z <= cells_z_reg);
    assign prod_z   = SUM_W'(corner.corner_z) * SUM_W'(sxy_reg);
    assign prod_y   = SUM_W'(corner.corner_y) * SUM_W'(sx_reg);
    assign addr_sum = prod_z + prod_y + SUM_W'(corner.corner_x);

    assign lookup_hit = ({1'b0, fwd_q} < next_id_reg) && (rev_q == addr_reg);

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        alloc      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (lookup_hit)
                    alloc = 1'b0;
                else
                    alloc = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration and datapath next values
    always_comb
    begin
        cells_x_next = cells_x_reg;
        cells_y_next = cells_y_reg;
        cells_z_next = cells_z_reg;
        next_id_next = next_id_reg;
        addr_next    = addr_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CELLS_X:
                begin
                    cells_x_next = clamp_cells(cfg_data);
                    next_id_next = '0;
                end
                CFG_CELLS_Y:
                begin
                    cells_y_next = clamp_cells(cfg_data);
                    next_id_next = '0;
                end
                CFG_CELLS_Z:
                begin
                    cells_z_next = clamp_cells(cfg_data);
                    next_id_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (accept)
        begin
            addr_next = addr_sum[ADDR_W-1:0];
            if (!in_range)
            begin
                done_next                   = 1'b1;
                result_next.corner_id       = '0;
                result_next.newly_allocated = 1'b0;
                result_next.out_of_range    = 1'b1;
            end
        end

        if (state_reg == ST_DECIDE)
        begin
            done_next                = 1'b1;
            result_next.out_of_range = 1'b0;
            if (alloc)
            begin
                result_next.corner_id       = next_id_reg[ID_W-1:0];
                result_next.newly_allocated = 1'b1;
                next_id_next                = next_id_reg + CNT_W'(1);
            end
            else
            begin
                result_next.corner_id       = fwd_q;
                result_next.newly_allocated = 1'b0;
            end
        end
    end

    assign sx_next  = {1'b0, cells_x_next} + SX_W'(1);
    assign sy_next  = {1'b0, cells_y_next} + SX_W'(1);
    assign sxy_next = SXY_W'(sx_next * sy_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CELL_W'(1);
            cells_y_reg <= CELL_W'(1);
            cells_z_reg <= CELL_W'(1);
            sx_reg      <= SX_W'(2);
            sxy_reg     <= SXY_W'(4);
            next_id_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cells_x_reg <= cells_x_next;
            cells_y_reg <= cells_y_next;
            cells_z_reg <= cells_z_next;
            sx_reg      <= sx_next;
            sxy_reg     <= sxy_next;
            next_id_reg <= next_id_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        result_reg <= result_next;
    end

    // corner table: address to id
    always_ff @(posedge clk)
    begin
        if (alloc)
            fwd_mem[addr_reg] <= next_id_reg[ID_W-1:0];
        if (state_reg == ST_LOOK)
            fwd_q <= fwd_mem[addr_reg];
    end

    // owner table: id to address
    always_ff @(posedge clk)
    begin
        if (alloc)
            rev_mem[next_id_reg[ID_W-1:0]] <= addr_reg;
        if (state_reg == ST_CHECK)
            rev_q <= rev_mem[fwd_q];
    end

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_DECIDE) || ($past(accept) && !$past(in_range)))
        else $error("result strobe without a finished lookup or range reject");

    a_new_id_is_counter: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.newly_allocated |-> {1'b0, result.corner_id} == next_id_reg - CNT_W'(1))
        else $error("fresh id does not match the counter step");

    a_hit_below_counter: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.newly_allocated && !result.out_of_range
            |-> {1'b0, result.corner_id} < next_id_reg)
        else $error("returned id was never handed out");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_of_range |-> (result.corner_id == '0) && !result.newly_allocated)
        else $error("out-of-range result carries an id");

    a_counter_steady_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == ST_IDLE && !$past(cfg_write) |-> $stable(next_id_reg))
        else $error("id counter moved without an allocation or setup");

endmodule

// ===== tb/tb_grid_corner_index_allocator.sv =====
// testbench: grid corner index allocator, directed table then random corners against a predictor
`timescale 1ns / 1ps

module tb_grid_corner_index_allocator;
    import gcia_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;
    localparam int MAX_PRINTS   = 200;
    localparam int RECENT_DEPTH = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_CORNER,
        ROW_CELLS
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CELL_W-1:0]    reg_value;
        gcia_in_t             corner;
        bit                   typed;
        gcia_out_t            answer;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    gcia_in_t             corner;
    logic                 done;
    gcia_out_t            result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CELL_W-1:0]    cfg_data;

    logic [CELL_W-1:0]    grid_cx;
    logic [CELL_W-1:0]    grid_cy;
    logic [CELL_W-1:0]    grid_cz;
    logic [ID_W-1:0]      issued_ids [int];
    logic [CNT_W-1:0]     id_counter;

    gcia_out_t            awaited_results [$];
    stim_row_t            directed_rows [$];
    bit                   use_typed;
    gcia_out_t            typed_answer;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;

    grid_corner_index_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .corner    (corner),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void set_cell_count(logic [CFG_IDX_W-1:0] idx,
                                           logic [CELL_W-1:0] value);
        logic [CELL_W-1:0] cells;
        cells = (int'(value) > MAX_CELLS_PER_AXIS) ? CELL_W'(MAX_CELLS_PER_AXIS) : value;
        case (idx)
            CFG_CELLS_X: grid_cx = cells;
            CFG_CELLS_Y: grid_cy = cells;
            CFG_CELLS_Z: grid_cz = cells;
            default: return;
        endcase
        issued_ids.delete();
        id_counter = '0;
    endfunction

    function automatic gcia_out_t lookup_corner_id(gcia_in_t c);
        gcia_out_t r;
        int        addr;
        r = '0;
        if (c.corner_x > grid_cx || c.corner_y > grid_cy || c.corner_z > grid_cz)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        addr = (int'(c.corner_z) * (int'(grid_cy) + 1) * (int'(grid_cx) + 1)
                + int'(c.corner_y) * (int'(grid_cx) + 1) + int'(c.corner_x)) % MEM_DEPTH;
        if (issued_ids.exists(addr))
        begin
            r.corner_id = issued_ids[addr];
        end
        else
        begin
            r.corner_id       = id_counter[ID_W-1:0];
            r.newly_allocated = 1'b1;
            issued_ids[addr]  = id_counter[ID_W-1:0];
            id_counter        = id_counter + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic add_corner(int x, int y, int z, bit has_answer = 1'b0, int id = 0,
                              bit fresh = 1'b0, bit outside = 1'b0);
        stim_row_t row;
        row.kind                   = ROW_CORNER;
        row.reg_index              = CFG_CELLS_X;
        row.reg_value              = '0;
        row.corner.corner_x        = COORD_W'(x);
        row.corner.corner_y        = COORD_W'(y);
        row.corner.corner_z        = COORD_W'(z);
        row.typed                  = has_answer;
        row.answer.corner_id       = ID_W'(id);
        row.answer.newly_allocated = fresh;
        row.answer.out_of_range    = outside;
        directed_rows.push_back(row);
    endtask

    task automatic add_cells(logic [CFG_IDX_W-1:0] idx, int value);
        stim_row_t row;
        row.kind      = ROW_CELLS;
        row.reg_index = idx;
        row.reg_value = CELL_W'(value);
        row.corner    = '0;
        row.typed     = 1'b0;
        row.answer    = '0;
        directed_rows.push_back(row);
    endtask

    task automatic drive_corner(gcia_in_t c, bit has_answer, gcia_out_t answer, int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        use_typed    = has_answer;
        typed_answer = answer;
        corner       = c;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // registers change only with the block idle
    task automatic write_cell_count(logic [CFG_IDX_W-1:0] idx, logic [CELL_W-1:0] value);
        start = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(posedge clk)
    begin
        gcia_out_t predicted;
        gcia_out_t oldest;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                set_cell_count(cfg_index, cfg_data);
            if (start && !busy)
            begin
                predicted = lookup_corner_id(corner);
                awaited_results.push_back(use_typed ? typed_answer : predicted);
            end
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result id %0d new %0b oor %0b",
                        result.corner_id, result.newly_allocated, result.out_of_range));
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (result.corner_id !== oldest.corner_id
                        || result.newly_allocated !== oldest.newly_allocated
                        || result.out_of_range !== oldest.out_of_range)
                    begin
                        report_mismatch($sformatf(
                            "id %0d new %0b oor %0b, expected id %0d new %0b oor %0b",
                            result.corner_id, result.newly_allocated, result.out_of_range,
                            oldest.corner_id, oldest.newly_allocated, oldest.out_of_range));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_IDX_W-1:0] cell_regs [3];
        gcia_in_t             recent [$];
        gcia_in_t             c;
        logic [31:0]          rnd;
        logic [CELL_W-1:0]    cells;
        int                   r;
        int                   gap;
        bit                   steady;
        bit                   fresh_pick;

        cell_regs    = '{CFG_CELLS_X, CFG_CELLS_Y, CFG_CELLS_Z};
        start        = 1'b0;
        corner       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_CELLS_X;
        cfg_data     = '0;
        use_typed    = 1'b0;
        typed_answer = '0;
        grid_cx      = CELL_W'(1);
        grid_cy      = CELL_W'(1);
        grid_cz      = CELL_W'(1);
        id_counter   = '0;
        rst_n        = 1'b0;

        // reset grid is 1x1x1 cells
        add_corner(0, 0, 0, 1, 0, 1, 0);
        add_corner(0, 0, 0, 1, 0, 0, 0);
        add_corner(1, 1, 1, 1, 1, 1, 0);
        add_corner(2, 0, 0, 1, 0, 0, 1);
        add_corner(0, 0, 2, 1, 0, 0, 1);
        add_corner(31, 31, 31, 1, 0, 0, 1);
        add_corner(1, 0, 0);
        // largest grid
        add_cells(CFG_CELLS_X, 31);
        add_cells(CFG_CELLS_Y, 31);
        add_cells(CFG_CELLS_Z, 31);
        add_corner(31, 31, 31, 1, 0, 1, 0);
        add_corner(0, 0, 0, 1, 1, 1, 0);
        add_corner(31, 31, 31, 1, 0, 0, 0);
        add_corner(16, 8, 4);
        // zero cells on x, then an ignored register write
        add_cells(CFG_CELLS_X, 0);
        add_corner(0, 5, 5, 1, 0, 1, 0);
        add_corner(1, 0, 0, 1, 0, 0, 1);
        add_cells(CFG_UNUSED, 31);
        add_corner(0, 5, 5, 1, 0, 0, 0);
        add_corner(0, 31, 31);
        // single corner grid
        add_cells(CFG_CELLS_Y, 0);
        add_cells(CFG_CELLS_Z, 0);
        add_corner(0, 0, 0, 1, 0, 1, 0);
        add_corner(0, 0, 1, 1, 0, 0, 1);
        add_corner(0, 1, 0, 1, 0, 0, 1);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CELLS)
                write_cell_count(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                drive_corner(directed_rows[i].corner, directed_rows[i].typed,
                             directed_rows[i].answer, $urandom_range(0, 2));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            steady = (p % 4 == 1);
            for (int a = 0; a < 3; a++)
            begin
                if (a == 0 || $urandom_range(0, 2) != 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        cells = '0;
                    else if (r < 35)
                        cells = CELL_W'(MAX_CELLS_PER_AXIS);
                    else if (r < 45)
                        cells = CELL_W'(1);
                    else
                        cells = CELL_W'($urandom_range(0, 31));
                    write_cell_count(cell_regs[a], cells);
                end
            end
            if ($urandom_range(0, 3) == 0)
                write_cell_count(CFG_UNUSED, CELL_W'($urandom_range(0, 31)));
            recent.delete();

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r          = $urandom_range(0, 99);
                fresh_pick = 1'b0;
                if (r < 12)
                begin
                    rnd = $urandom;
                    c   = rnd[$bits(gcia_in_t)-1:0];
                end
                else if (r < 40 && recent.size() != 0)
                begin
                    c = recent[$urandom_range(0, recent.size() - 1)];
                end
                else
                begin
                    c.corner_x = COORD_W'($urandom_range(0, int'(grid_cx)));
                    c.corner_y = COORD_W'($urandom_range(0, int'(grid_cy)));
                    c.corner_z = COORD_W'($urandom_range(0, int'(grid_cz)));
                    fresh_pick = 1'b1;
                end
                if (fresh_pick)
                begin
                    recent.push_back(c);
                    if (recent.size() > RECENT_DEPTH)
                        void'(recent.pop_front());
                end

                r = $urandom_range(0, 99);
                if (steady || r < 60)
                    gap = 0;
                else if (r < 92)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(8, 40);
                drive_corner(c, 1'b0, '0, gap);
            end
        end

        start = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gcia_pkg.sv
rtl/core/grid_corner_index_allocator.sv
tb/tb_grid_corner_index_allocator.sv
